/* src/ptl_pkg.sv */
// Shared constants for the point-to-line distance unit.
// No dependencies; every other file except ptl_points_if imports this package.
package ptl_pkg;

  // Default coordinate width (signed Q15.16).
  localparam int PTL_COORD_BITS = 32;

  // Width of the distance result in Q17.16.
  localparam int DIST_BITS = 33;

endpackage

/* src/ptl_points_if.sv */
// Input channel carrying one query point and two line points per beat.
// Depends on nothing; the width follows COORD_BITS.
interface ptl_points_if #(
  parameter int COORD_BITS = 32
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] query_x;
  logic signed [COORD_BITS-1:0] query_y;
  logic signed [COORD_BITS-1:0] query_z;
  logic signed [COORD_BITS-1:0] line_a_x;
  logic signed [COORD_BITS-1:0] line_a_y;
  logic signed [COORD_BITS-1:0] line_a_z;
  logic signed [COORD_BITS-1:0] line_b_x;
  logic signed [COORD_BITS-1:0] line_b_y;
  logic signed [COORD_BITS-1:0] line_b_z;

  modport source (
    output valid, query_x, query_y, query_z, line_a_x, line_a_y, line_a_z,
           line_b_x, line_b_y, line_b_z,
    input  ready
  );
  modport sink (
    input  valid, query_x, query_y, query_z, line_a_x, line_a_y, line_a_z,
           line_b_x, line_b_y, line_b_z,
    output ready
  );
endinterface

/* src/ptl_result_if.sv */
// Output channel carrying one distance result per beat.
// Depends on ptl_pkg for the result width.
interface ptl_result_if ();
  import ptl_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [DIST_BITS-1:0] distance;
  logic                 degenerate;

  modport source (output valid, distance, degenerate, input ready);
  modport sink (input valid, distance, degenerate, output ready);
endinterface

/* src/ptl_front.sv */
// Front stages: difference vectors, cross product terms, |v|^2 and |u x v| magnitudes.
// Depends on ptl_pkg; three register stages, all advancing on en.
module ptl_front #(
  parameter int COORD_BITS = ptl_pkg::PTL_COORD_BITS,
  parameter int MAG_W      = 2 * (COORD_BITS + 1),
  parameter int DEN_W      = 2 * (COORD_BITS + 1) + 2
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         valid_in,
  input  logic signed [COORD_BITS-1:0] qx,
  input  logic signed [COORD_BITS-1:0] qy,
  input  logic signed [COORD_BITS-1:0] qz,
  input  logic signed [COORD_BITS-1:0] ax,
  input  logic signed [COORD_BITS-1:0] ay,
  input  logic signed [COORD_BITS-1:0] az,
  input  logic signed [COORD_BITS-1:0] bx,
  input  logic signed [COORD_BITS-1:0] by,
  input  logic signed [COORD_BITS-1:0] bz,
  output logic                         valid_out,
  output logic [MAG_W-1:0]             cabs [3],
  output logic [DEN_W-1:0]             den
);
  import ptl_pkg::*;

  localparam int D  = COORD_BITS + 1;
  localparam int PW = 2 * D;

  logic                vld1, vld2;
  logic signed [D-1:0]  u [3];
  logic signed [D-1:0]  v [3];
  logic signed [PW-1:0] pa [3];
  logic signed [PW-1:0] pb [3];
  logic signed [PW-1:0] vs [3];
  logic signed [PW:0]   cr [3];
  logic [MAG_W-1:0]     cmag [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1      <= 1'b0;
      vld2      <= 1'b0;
      valid_out <= 1'b0;
    end else if (en) begin
      vld1      <= valid_in;
      vld2      <= vld1;
      valid_out <= vld2;
    end
  end

  // Stage 1: exact differences, one bit wider than the coordinates.
  always_ff @(posedge clk) begin
    if (en) begin
      u[0] <= D'(qx) - D'(ax);
      u[1] <= D'(qy) - D'(ay);
      u[2] <= D'(qz) - D'(az);
      v[0] <= D'(bx) - D'(ax);
      v[1] <= D'(by) - D'(ay);
      v[2] <= D'(bz) - D'(az);
    end
  end

  // Stage 2: the six cross product terms and the three squares of v.
  always_ff @(posedge clk) begin
    if (en) begin
      pa[0] <= u[1] * v[2];
      pb[0] <= u[2] * v[1];
      pa[1] <= u[2] * v[0];
      pb[1] <= u[0] * v[2];
      pa[2] <= u[0] * v[1];
      pb[2] <= u[1] * v[0];
      vs[0] <= v[0] * v[0];
      vs[1] <= v[1] * v[1];
      vs[2] <= v[2] * v[2];
    end
  end

  // Stage 3: cross product components reduced to magnitudes, and |v|^2.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cr[i]   = (PW + 1)'(pa[i]) - (PW + 1)'(pb[i]);
      cmag[i] = cr[i][PW] ? MAG_W'(-cr[i]) : MAG_W'(cr[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        cabs[i] <= cmag[i];
      end
      den <= DEN_W'(unsigned'(vs[0])) + DEN_W'(unsigned'(vs[1]))
           + DEN_W'(unsigned'(vs[2]));
    end
  end

endmodule

/* src/ptl_square.sv */
// Squares the cross product magnitudes from split half-width products and sums them.
// Depends on ptl_pkg; three register stages, all advancing on en.
module ptl_square #(
  parameter int MAG_W = 66,
  parameter int DEN_W = 68,
  parameter int NUM_W = 2 * MAG_W + 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             valid_in,
  input  logic [MAG_W-1:0] cabs [3],
  input  logic [DEN_W-1:0] den_in,
  output logic             valid_out,
  output logic [NUM_W-1:0] num,
  output logic [DEN_W-1:0] den_out
);
  import ptl_pkg::*;

  localparam int LO   = MAG_W / 2;
  localparam int HI   = MAG_W - LO;
  localparam int SQ_W = 2 * MAG_W;

  logic                 vld4, vld5;
  logic [2*HI-1:0]      hh [3];
  logic [HI+LO-1:0]     hl [3];
  logic [2*LO-1:0]      ll [3];
  logic [SQ_W-1:0]      sq [3];
  logic [DEN_W-1:0]     den4, den5;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld4      <= 1'b0;
      vld5      <= 1'b0;
      valid_out <= 1'b0;
    end else if (en) begin
      vld4      <= valid_in;
      vld5      <= vld4;
      valid_out <= vld5;
    end
  end

  // Stage 4: high*high, high*low and low*low partial products per component.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        hh[i] <= cabs[i][MAG_W-1:LO] * cabs[i][MAG_W-1:LO];
        hl[i] <= cabs[i][MAG_W-1:LO] * cabs[i][LO-1:0];
        ll[i] <= cabs[i][LO-1:0] * cabs[i][LO-1:0];
      end
      den4 <= den_in;
    end
  end

  // Stage 5: recombine each square; the cross term counts twice.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq[i] <= (SQ_W'(hh[i]) << (2 * LO)) + (SQ_W'(hl[i]) << (LO + 1)) + SQ_W'(ll[i]);
      end
      den5 <= den4;
    end
  end

  // Stage 6: |u x v|^2.
  always_ff @(posedge clk) begin
    if (en) begin
      num     <= NUM_W'(sq[0]) + NUM_W'(sq[1]) + NUM_W'(sq[2]);
      den_out <= den5;
    end
  end

endmodule

/* src/ptl_root_stage.sv */
// One bit of the floor(sqrt(num/den)) search: tries setting bit BIT of the result.
// Depends on ptl_pkg; keeps running values p = d*d*den and q = d*den so no multiplier is needed.
module ptl_root_stage #(
  parameter int NUM_W = 134,
  parameter int DEN_W = 68,
  parameter int RW    = 135,
  parameter int BIT   = 0
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           valid_in,
  input  logic                           degen_in,
  input  logic [NUM_W-1:0]               num_in,
  input  logic [DEN_W-1:0]               den_in,
  input  logic [RW-1:0]                  p_in,
  input  logic [RW-1:0]                  q_in,
  input  logic [ptl_pkg::DIST_BITS-1:0]  d_in,
  output logic                           valid_out,
  output logic                           degen_out,
  output logic [NUM_W-1:0]               num_out,
  output logic [DEN_W-1:0]               den_out,
  output logic [RW-1:0]                  p_out,
  output logic [RW-1:0]                  q_out,
  output logic [ptl_pkg::DIST_BITS-1:0]  d_out
);
  import ptl_pkg::*;

  logic [RW-1:0] cand;
  logic          take;

  // (d + 2^k)^2 * den = p + q * 2^(k+1) + den * 2^(2k)
  assign cand = p_in + (q_in << (BIT + 1)) + (RW'(den_in) << (2 * BIT));
  assign take = cand <= RW'(num_in);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      degen_out <= degen_in;
      num_out   <= num_in;
      den_out   <= den_in;
      p_out     <= take ? cand : p_in;
      q_out     <= take ? q_in + (RW'(den_in) << BIT) : q_in;
      d_out     <= take ? (d_in | (DIST_BITS'(1) << BIT)) : d_in;
    end
  end

endmodule

/* src/point_to_line_distance_unit.sv */
// Top level of the point-to-line distance unit: front, squaring and root pipeline.
// Depends on ptl_pkg, ptl_points_if, ptl_result_if, ptl_front, ptl_square, ptl_root_stage.
//
//   Channel | Role  | Beat contents
//   --------+-------+-----------------------------------------------------------
//   points  | sink  | query_x/y/z, line_a_x/y/z, line_b_x/y/z, signed Q15.16
//   result  | source| distance (33-bit unsigned Q17.16), degenerate flag
//
// One beat is taken every cycle unless the result is stalled. The pipeline has three front
// stages, three squaring stages and one stage per result bit of the square root search.
// The last root stage is the output register. Reset (synchronous, active
// high) clears only the valid bits. When the result is stalled, every stage
// holds, so nothing is dropped or repeated and points.ready falls with it.
module point_to_line_distance_unit #(
  parameter int COORD_BITS = ptl_pkg::PTL_COORD_BITS
) (
  input logic          clk,
  input logic          rst,
  ptl_points_if.sink   points,
  ptl_result_if.source result
);
  import ptl_pkg::*;

  // Widths of the exact intermediate values.
  localparam int MAG_W = 2 * (COORD_BITS + 1);
  localparam int DEN_W = 2 * (COORD_BITS + 1) + 2;
  localparam int NUM_W = 2 * MAG_W + 2;
  localparam int PW    = DEN_W + 2 * DIST_BITS;
  localparam int RW    = ((NUM_W > PW) ? NUM_W : PW) + 1;

  logic             en;
  logic             front_valid, sq_valid;
  logic [MAG_W-1:0] cabs [3];
  logic [DEN_W-1:0] front_den, sq_den;
  logic [NUM_W-1:0] sq_num;

  // Per-stage signals of the root search; index 0 feeds the first stage.
  logic [DIST_BITS:0]   v_s;
  logic [DIST_BITS:0]   degen_s;
  logic [NUM_W-1:0]     num_s [DIST_BITS+1];
  logic [DEN_W-1:0]     den_s [DIST_BITS+1];
  logic [RW-1:0]        p_s   [DIST_BITS+1];
  logic [RW-1:0]        q_s   [DIST_BITS+1];
  logic [DIST_BITS-1:0] d_s   [DIST_BITS+1];

  // The whole pipeline moves whenever the output register is free or drained.
  assign en           = !result.valid || result.ready;
  assign points.ready = en;

  ptl_front #(
    .COORD_BITS(COORD_BITS),
    .MAG_W     (MAG_W),
    .DEN_W     (DEN_W)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .valid_in (points.valid),
    .qx       (points.query_x),
    .qy       (points.query_y),
    .qz       (points.query_z),
    .ax       (points.line_a_x),
    .ay       (points.line_a_y),
    .az       (points.line_a_z),
    .bx       (points.line_b_x),
    .by       (points.line_b_y),
    .bz       (points.line_b_z),
    .valid_out(front_valid),
    .cabs     (cabs),
    .den      (front_den)
  );

  ptl_square #(
    .MAG_W(MAG_W),
    .DEN_W(DEN_W),
    .NUM_W(NUM_W)
  ) u_square (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .valid_in (front_valid),
    .cabs     (cabs),
    .den_in   (front_den),
    .valid_out(sq_valid),
    .num      (sq_num),
    .den_out  (sq_den)
  );

  // The search starts from d = 0. A zero |v|^2 marks coincident line points.
  assign v_s[0]     = sq_valid;
  assign degen_s[0] = (sq_den == '0);
  assign num_s[0]   = sq_num;
  assign den_s[0]   = sq_den;
  assign p_s[0]     = '0;
  assign q_s[0]     = '0;
  assign d_s[0]     = '0;

  // Stage k decides result bit DIST_BITS-1-k, most significant first.
  for (genvar k = 0; k < DIST_BITS; k++) begin : g_root
    ptl_root_stage #(
      .NUM_W(NUM_W),
      .DEN_W(DEN_W),
      .RW   (RW),
      .BIT  (DIST_BITS - 1 - k)
    ) u_stage (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .valid_in (v_s[k]),
      .degen_in (degen_s[k]),
      .num_in   (num_s[k]),
      .den_in   (den_s[k]),
      .p_in     (p_s[k]),
      .q_in     (q_s[k]),
      .d_in     (d_s[k]),
      .valid_out(v_s[k+1]),
      .degen_out(degen_s[k+1]),
      .num_out  (num_s[k+1]),
      .den_out  (den_s[k+1]),
      .p_out    (p_s[k+1]),
      .q_out    (q_s[k+1]),
      .d_out    (d_s[k+1])
    );
  end

  // With zero |v|^2 every trial passes, so the distance is forced to zero.
  assign result.valid      = v_s[DIST_BITS];
  assign result.degenerate = degen_s[DIST_BITS];
  assign result.distance   = degen_s[DIST_BITS] ? '0 : d_s[DIST_BITS];

  // A degenerate beat always reports zero distance.
  assert property (@(posedge clk) disable iff (rst)
    result.valid && result.degenerate |-> result.distance == '0)
    else $error("degenerate beat with nonzero distance");

  // A stall freezes every valid bit of the pipeline.
  assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(v_s))
    else $error("pipeline moved during a stall");

  // The delivered distance never overshoots: d*d*|v|^2 <= |u x v|^2.
  assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.degenerate |-> p_s[DIST_BITS] <= RW'(num_s[DIST_BITS]))
    else $error("root search overshoot");

endmodule
